>>> sv/mprc_pkg.sv
// Shared types and constants for the multi-pattern replace block.
package mprc_pkg;

    localparam int BYTE_W = 8;
    localparam int FUNC_W = 2;
    localparam int SLOT_W = 2;
    localparam int OFFS_W = 4;
    localparam int LEN_W  = 5;
    localparam int MASK_W = 4;
    // Wide enough to compare lengths, fills and cell positions up to 127.
    localparam int CMP_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_DATA    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPLACE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_LENGTH  = 2'd3;

    // Controls broadcast to every window cell.
    typedef struct packed {
        logic                append;
        logic                shift;
        logic                replace;
        logic                wr_search;
        logic                wr_replace;
        logic [BYTE_W-1:0]   wr_byte;
        logic [BYTE_W-1:0]   data_byte;
    } cell_ctrl_t;

endpackage

>>> sv/mprc_cell.sv
// One window cell: a stream byte plus this position's search and replace bytes.
module mprc_cell #(
    parameter int NUM_PATTERNS = 4,
    parameter int PAT_W        = 2
) (
    input  logic                        aclk,
    input  mprc_pkg::cell_ctrl_t        ctrl,
    input  logic                        sel_append,
    input  logic                        sel_write,
    input  logic                        sel_replace,
    input  logic [PAT_W-1:0]            wr_idx,
    input  logic [PAT_W-1:0]            pat_idx,
    input  logic [mprc_pkg::BYTE_W-1:0] next_byte,
    output logic [mprc_pkg::BYTE_W-1:0] byte_q,
    output logic                        match
);

    logic [mprc_pkg::BYTE_W-1:0] byte_reg;
    logic [mprc_pkg::BYTE_W-1:0] search_reg  [NUM_PATTERNS];
    logic [mprc_pkg::BYTE_W-1:0] replace_reg [NUM_PATTERNS];

    always_ff @(posedge aclk) begin
        if (ctrl.append && sel_append) begin
            byte_reg <= ctrl.data_byte;
        end else if (ctrl.shift) begin
            byte_reg <= next_byte;
        end else if (ctrl.replace && sel_replace) begin
            byte_reg <= replace_reg[pat_idx];
        end
        if (ctrl.wr_search && sel_write) begin
            search_reg[wr_idx] <= ctrl.wr_byte;
        end
        if (ctrl.wr_replace && sel_write) begin
            replace_reg[wr_idx] <= ctrl.wr_byte;
        end
    end

    assign byte_q = byte_reg;
    assign match  = (byte_reg == search_reg[pat_idx]);

endmodule

>>> sv/multi_pattern_replace_once.sv
// Top level of the multi-pattern, apply-once byte search and replace block.
//
// Bytes enter a window of MAX_LEN cells. Once the window is full, or when a
// byte with tlast arrives, the head position is processed: the patterns are
// tried one per cycle in table order on a shared compare across all cells, a
// pattern that has not been applied yet and matches rewrites the cells it
// covers, and then the head byte leaves through the output register while the
// cells shift one place toward the head. A table write or a byte that only
// fills the window leaves the block idle, ready for the next input. A byte
// with tlast flushes the whole window, processing each pending byte in turn.
// Table writes use the same input channel, selected by tuser. A length write
// clears that entry's applied mark; the marks otherwise persist across
// streams. The input side is taken again as soon as processing ends, even
// while the output register still holds a transfer that waits to be taken.
module multi_pattern_replace_once #(
    parameter int NUM_PATTERNS = 4,
    parameter int MAX_LEN      = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // data_byte[7:0], slot[9:8], offset[13:10], table_byte[21:14],
    // pattern_length[26:22], zeros above.
    input  logic [31:0] s_tdata,
    // func[1:0].
    input  logic [1:0]  s_tuser,
    // stream_end.
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // out_byte[7:0], applied_mask[11:8], zeros above.
    output logic [15:0] m_tdata,
    // out_last.
    output logic        m_tlast
);

    localparam int PAT_W  = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int FILL_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W  = mprc_pkg::CMP_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_MATCH = 2'd1;
    localparam logic [1:0] ST_EMIT  = 2'd2;

    logic [1:0]                 state_reg, state_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [PAT_W-1:0]           pat_reg, pat_next;
    logic                       flush_reg, flush_next;
    logic [NUM_PATTERNS-1:0]    applied_reg, applied_next;
    logic [mprc_pkg::LEN_W-1:0] len_reg [NUM_PATTERNS];

    logic                          out_valid_reg;
    logic [mprc_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                          out_last_reg;
    logic [mprc_pkg::MASK_W-1:0]   out_mask_reg;

    // Input fields.
    logic [mprc_pkg::FUNC_W-1:0] in_func;
    logic [mprc_pkg::BYTE_W-1:0] in_data;
    logic [mprc_pkg::SLOT_W-1:0] in_slot;
    logic [mprc_pkg::OFFS_W-1:0] in_offs;
    logic [mprc_pkg::BYTE_W-1:0] in_tbyte;
    logic [mprc_pkg::LEN_W-1:0]  in_len;

    assign in_func  = s_tuser;
    assign in_data  = s_tdata[7:0];
    assign in_slot  = s_tdata[9:8];
    assign in_offs  = s_tdata[13:10];
    assign in_tbyte = s_tdata[21:14];
    assign in_len   = s_tdata[26:22];

    logic in_xfer, slot_ok, offs_ok, out_free, emit_go;
    logic [PAT_W-1:0] slot_idx;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign slot_ok  = (CMP_W'(in_slot) < CMP_W'(NUM_PATTERNS));
    assign offs_ok  = (CMP_W'(in_offs) < CMP_W'(MAX_LEN));
    assign slot_idx = PAT_W'(in_slot);
    assign out_free = !out_valid_reg || m_tready;
    assign emit_go  = (state_reg == ST_EMIT) && out_free;

    // Current pattern's eligibility and the shared match reduction.
    logic [mprc_pkg::LEN_W-1:0] cur_len;
    logic                       eligible, hit;
    logic [MAX_LEN-1:0]         in_pat, cell_match;

    assign cur_len  = len_reg[pat_reg];
    assign eligible = !applied_reg[pat_reg] && (cur_len != '0)
                   && (CMP_W'(cur_len) <= CMP_W'(MAX_LEN))
                   && (CMP_W'(cur_len) <= CMP_W'(fill_reg));
    assign hit      = (state_reg == ST_MATCH) && eligible && (&(cell_match | ~in_pat));

    mprc_pkg::cell_ctrl_t ctrl;
    assign ctrl.append     = in_xfer && (in_func == mprc_pkg::FUNC_DATA);
    assign ctrl.shift      = emit_go;
    assign ctrl.replace    = hit;
    assign ctrl.wr_search  = in_xfer && (in_func == mprc_pkg::FUNC_SEARCH) && slot_ok && offs_ok;
    assign ctrl.wr_replace = in_xfer && (in_func == mprc_pkg::FUNC_REPLACE) && slot_ok && offs_ok;
    assign ctrl.wr_byte    = in_tbyte;
    assign ctrl.data_byte  = in_data;

    logic [mprc_pkg::BYTE_W-1:0] cell_byte [MAX_LEN+1];
    assign cell_byte[MAX_LEN] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_LEN; gi++) begin : g_cell
            assign in_pat[gi] = (CMP_W'(gi) < CMP_W'(cur_len));
            mprc_cell #(
                .NUM_PATTERNS(NUM_PATTERNS),
                .PAT_W       (PAT_W)
            ) u_cell (
                .aclk       (aclk),
                .ctrl       (ctrl),
                .sel_append (CMP_W'(fill_reg) == CMP_W'(gi)),
                .sel_write  (CMP_W'(in_offs) == CMP_W'(gi)),
                .sel_replace(in_pat[gi]),
                .wr_idx     (slot_idx),
                .pat_idx    (pat_reg),
                .next_byte  (cell_byte[gi+1]),
                .byte_q     (cell_byte[gi]),
                .match      (cell_match[gi])
            );
        end
    endgenerate

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        pat_next     = pat_reg;
        flush_next   = flush_reg;
        applied_next = applied_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && in_func == mprc_pkg::FUNC_DATA) begin
                    fill_next = fill_reg + 1'b1;
                    pat_next  = '0;
                    if (s_tlast || (CMP_W'(fill_reg) + 1'b1 == CMP_W'(MAX_LEN))) begin
                        flush_next = s_tlast;
                        state_next = ST_MATCH;
                    end
                end else if (in_xfer && in_func == mprc_pkg::FUNC_LENGTH && slot_ok) begin
                    applied_next[slot_idx] = 1'b0;
                end
            end
            ST_MATCH: begin
                if (hit) begin
                    applied_next[pat_reg] = 1'b1;
                end
                if (CMP_W'(pat_reg) == CMP_W'(NUM_PATTERNS - 1)) begin
                    state_next = ST_EMIT;
                end else begin
                    pat_next = pat_reg + 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    fill_next = fill_reg - 1'b1;
                    pat_next  = '0;
                    if (flush_reg && fill_reg > FILL_W'(1)) begin
                        state_next = ST_MATCH;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    logic [mprc_pkg::MASK_W-1:0] mask_now;
    always_comb begin
        mask_now = '0;
        for (int j = 0; j < NUM_PATTERNS && j < mprc_pkg::MASK_W; j++) begin
            mask_now[j] = applied_reg[j];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            pat_reg       <= '0;
            flush_reg     <= 1'b0;
            applied_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NUM_PATTERNS; j++) begin
                len_reg[j] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            pat_reg     <= pat_next;
            flush_reg   <= flush_next;
            applied_reg <= applied_next;
            if (in_xfer && in_func == mprc_pkg::FUNC_LENGTH && slot_ok) begin
                len_reg[slot_idx] <= in_len;
            end
            if (emit_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Output payload; the applied marks are final once matching has ended.
    always_ff @(posedge aclk) begin
        if (emit_go) begin
            out_byte_reg <= cell_byte[0];
            out_last_reg <= flush_reg && (fill_reg == FILL_W'(1));
            out_mask_reg <= mask_now;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_mask_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;

    // The window never holds more bytes than it has cells.
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        CMP_W'(fill_reg) <= CMP_W'(MAX_LEN))
        else $error("window fill beyond capacity");

    // Applied marks are only ever set while matching.
    a_applied_set: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_MATCH |=> (applied_reg & ~$past(applied_reg)) == '0)
        else $error("applied mark set outside matching");

    // Emitting the last byte of a flush leaves the window empty.
    a_flush_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_go && flush_reg && fill_reg == FILL_W'(1) |=> fill_reg == '0)
        else $error("window not empty after flush");

    // No input is taken while a head position is being processed.
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MATCH || state_reg == ST_EMIT) |-> !in_xfer)
        else $error("input taken during processing");

endmodule
